FILE: rtl/tpd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the telemetry packet deframer.
// No dependencies; imported by every module of the block.
package tpd_pkg;

	localparam int GROUP_SLOTS_DEF         = 8;
	localparam int WORDS_PER_SUBPACKET_DEF = 4;
	localparam int MASK_W                  = 16;
	localparam int WORD_SHIFT_W            = 24;
	localparam int CFG_INDEX_W             = 2;

	localparam logic [7:0] HDR_FIRST  = 8'h50;
	localparam logic [7:0] HDR_SECOND = 8'h41;

	localparam logic [7:0] CONTROL_ID_RST  = 8'd49;
	localparam logic [7:0] GUIDANCE_ID_RST = 8'd54;
	localparam logic [7:0] END_MARKER_RST  = 8'd35;

	localparam logic [1:0] CONTROL_SLOTS  = 2'd3;
	localparam logic [1:0] GUIDANCE_SLOTS = 2'd2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_CONTROL_ID  = 2'd0,
		CFG_GUIDANCE_ID = 2'd1,
		CFG_END_MARKER  = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		KIND_CONTROL  = 2'd0,
		KIND_GUIDANCE = 2'd1,
		KIND_STOP     = 2'd2,
		KIND_NONE     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		SK_CONTROL  = 2'd0,
		SK_GUIDANCE = 2'd1,
		SK_RSVD     = 2'd2,
		SK_UNKNOWN  = 2'd3
	} sub_kind_t;

	typedef enum logic [8:0] {
		PH_IDLE    = 9'b0_0000_0001,
		PH_HDR2    = 9'b0_0000_0010,
		PH_MASK_LO = 9'b0_0000_0100,
		PH_MASK_HI = 9'b0_0000_1000,
		PH_ID      = 9'b0_0001_0000,
		PH_WORDS   = 9'b0_0010_0000,
		PH_CRC     = 9'b0_0100_0000,
		PH_TERM    = 9'b0_1000_0000,
		PH_IGNORE  = 9'b1_0000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_start;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  slot;
		logic [31:0] value_bits;
		logic        stop_flag;
	} out_item_t;

	typedef struct packed {
		logic [7:0] control_id;
		logic [7:0] guidance_id;
		logic [7:0] end_marker;
	} cfg_t;

endpackage

FILE: rtl/tpd_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the deframer: id bytes and end marker.
// Depends on tpd_pkg.
module tpd_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [tpd_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [7:0]                   wr_data,
	output tpd_pkg::cfg_t                cfg
);
	import tpd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.control_id  <= CONTROL_ID_RST;
			cfg_q.guidance_id <= GUIDANCE_ID_RST;
			cfg_q.end_marker  <= END_MARKER_RST;
		end else if (wr_en) begin
			unique case (cfg_index_t'(wr_index))
				CFG_CONTROL_ID:  cfg_q.control_id  <= wr_data;
				CFG_GUIDANCE_ID: cfg_q.guidance_id <= wr_data;
				CFG_END_MARKER:  cfg_q.end_marker  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/tpd_parser.sv
`timescale 1ns / 1ps
// Byte-level packet parser: header check, group mask, subpacket words, terminator.
// Depends on tpd_pkg; produces at most one result per accepted byte.
module tpd_parser #(
	parameter int GROUP_SLOTS         = tpd_pkg::GROUP_SLOTS_DEF,
	parameter int WORDS_PER_SUBPACKET = tpd_pkg::WORDS_PER_SUBPACKET_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  tpd_pkg::in_item_t   item,
	input  tpd_pkg::cfg_t       cfg,
	output logic                res_valid,
	output tpd_pkg::out_item_t  res
);
	import tpd_pkg::*;

	localparam int GB_W  = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
	localparam int TOTAL = 4 * WORDS_PER_SUBPACKET;
	localparam int BC_W  = (TOTAL > 4) ? $clog2(TOTAL) : 2;
	localparam logic [BC_W-1:0] BC_LAST = BC_W'(TOTAL - 1);

	phase_t                  phase_q;
	logic [MASK_W-1:0]       mask_q;
	logic [GB_W-1:0]         group_bit_q;
	logic [BC_W-1:0]         byte_count_q;
	sub_kind_t               sub_kind_q;
	logic [WORD_SHIFT_W-1:0] word_shift_q;

	phase_t                  phase_d;
	logic [MASK_W-1:0]       mask_d;
	logic [GB_W-1:0]         group_bit_d;
	logic [BC_W-1:0]         byte_count_d;
	sub_kind_t               sub_kind_d;
	logic [WORD_SHIFT_W-1:0] word_shift_d;

	logic [MASK_W-1:0]       seek_mask;
	logic [GB_W:0]           seek_from;
	logic                    seek_found;
	logic [GB_W-1:0]         seek_idx;
	logic [7:0]              b;
	logic [1:0]              pos;
	logic [2:0]              word;

	assign b    = item.data_byte;
	assign pos  = byte_count_q[1:0];
	assign word = 3'(byte_count_q >> 2);

	assign seek_mask = (phase_q == PH_MASK_HI) ? {b, mask_q[7:0]} : mask_q;
	assign seek_from = (phase_q == PH_MASK_HI) ? (GB_W+1)'(0) :
		(GB_W+1)'(group_bit_q) + (GB_W+1)'(1);

	// lowest set mask bit at or above seek_from
	always_comb begin
		seek_found = 1'b0;
		seek_idx   = '0;
		for (int i = GROUP_SLOTS - 1; i >= 0; i--) begin
			if (seek_mask[i] && ((GB_W+1)'(i) >= seek_from)) begin
				seek_found = 1'b1;
				seek_idx   = GB_W'(i);
			end
		end
	end

	always_comb begin
		phase_d      = phase_q;
		mask_d       = mask_q;
		group_bit_d  = group_bit_q;
		byte_count_d = byte_count_q;
		sub_kind_d   = sub_kind_q;
		word_shift_d = word_shift_q;
		res_valid    = 1'b0;
		res.kind       = KIND_CONTROL;
		res.slot       = '0;
		res.value_bits = '0;
		res.stop_flag  = 1'b0;

		if (item.packet_start) begin
			mask_d       = '0;
			group_bit_d  = '0;
			byte_count_d = '0;
			sub_kind_d   = SK_CONTROL;
			word_shift_d = '0;
			phase_d      = (b == HDR_FIRST) ? PH_HDR2 : PH_IGNORE;
		end else begin
			unique case (phase_q)
				PH_HDR2: begin
					phase_d = (b == HDR_SECOND) ? PH_MASK_LO : PH_IGNORE;
				end
				PH_MASK_LO: begin
					mask_d  = {8'h00, b};
					phase_d = PH_MASK_HI;
				end
				PH_MASK_HI: begin
					mask_d      = {b, mask_q[7:0]};
					group_bit_d = seek_found ? seek_idx : '0;
					phase_d     = seek_found ? PH_ID : PH_TERM;
				end
				PH_ID: begin
					if (b == cfg.control_id) begin
						sub_kind_d = SK_CONTROL;
					end else if (b == cfg.guidance_id) begin
						sub_kind_d = SK_GUIDANCE;
					end else begin
						sub_kind_d = SK_UNKNOWN;
					end
					byte_count_d = '0;
					word_shift_d = '0;
					phase_d      = PH_WORDS;
				end
				PH_WORDS: begin
					case (pos)
						2'd0: word_shift_d = {word_shift_q[23:8], b};
						2'd1: word_shift_d = {word_shift_q[23:16], b, word_shift_q[7:0]};
						2'd2: word_shift_d = {b, word_shift_q[15:0]};
						default: begin
							word_shift_d   = '0;
							res.slot       = word[1:0];
							res.value_bits = {b, word_shift_q};
							if (sub_kind_q == SK_CONTROL && word <= 3'(CONTROL_SLOTS)) begin
								res_valid = 1'b1;
								res.kind  = KIND_CONTROL;
							end else if (sub_kind_q == SK_GUIDANCE &&
									word <= 3'(GUIDANCE_SLOTS)) begin
								res_valid = 1'b1;
								res.kind  = KIND_GUIDANCE;
							end
						end
					endcase
					if (byte_count_q == BC_LAST) begin
						byte_count_d = '0;
						phase_d      = PH_CRC;
					end else begin
						byte_count_d = byte_count_q + BC_W'(1);
					end
				end
				PH_CRC: begin
					group_bit_d = seek_found ? seek_idx : '0;
					phase_d     = seek_found ? PH_ID : PH_TERM;
				end
				PH_TERM: begin
					phase_d       = PH_IGNORE;
					res_valid     = 1'b1;
					res.kind      = KIND_STOP;
					res.stop_flag = (b == cfg.end_marker);
				end
				default: ;
			endcase
		end
		if (!accept) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			mask_q       <= '0;
			group_bit_q  <= '0;
			byte_count_q <= '0;
			sub_kind_q   <= SK_CONTROL;
			word_shift_q <= '0;
		end else if (accept) begin
			phase_q      <= phase_d;
			mask_q       <= mask_d;
			group_bit_q  <= group_bit_d;
			byte_count_q <= byte_count_d;
			sub_kind_q   <= sub_kind_d;
			word_shift_q <= word_shift_d;
		end
	end

endmodule

FILE: rtl/tpd_out_skid.sv
`timescale 1ns / 1ps
// Result register with a skid stage, so the input side keeps flowing while
// a result waits. Depends on tpd_pkg.
module tpd_out_skid (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tpd_pkg::out_item_t push_data,
	output logic               full,
	output logic               out_valid,
	input  logic               out_stall,
	output tpd_pkg::out_item_t out_data
);
	import tpd_pkg::*;

	logic      main_v_q;
	logic      skid_v_q;
	out_item_t main_q;
	out_item_t skid_q;
	logic      main_free;

	assign main_free = !main_v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (main_free) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end
		if (!main_free && push) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

endmodule

FILE: rtl/telemetry_packet_deframer_core.sv
`timescale 1ns / 1ps
// Top level of the telemetry packet deframer.
// Depends on tpd_pkg, tpd_cfg_regs, tpd_parser and tpd_out_skid.
//
//   channel   handshake            payload
//   in        in_valid / in_stall  in_data   (data_byte, packet_start)
//   out       out_valid / out_stall out_data (kind, slot, value_bits, stop_flag)
//   cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; out_data is a registered result.
// Parser state sits in one register bank updated per byte; results pass
// through a result register and a one-entry skid stage.
// in_stall rises only while the skid stage holds a result.
// Reset returns the registers to '1', '6', '#' and the parser to idle.
module telemetry_packet_deframer_core #(
	parameter int GROUP_SLOTS         = tpd_pkg::GROUP_SLOTS_DEF,
	parameter int WORDS_PER_SUBPACKET = tpd_pkg::WORDS_PER_SUBPACKET_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  tpd_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output tpd_pkg::out_item_t              out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tpd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data
);
	import tpd_pkg::*;

	cfg_t      cfg;
	logic      accept;
	logic      res_valid;
	out_item_t res;
	logic      skid_full;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_full;
	assign accept    = in_valid && !skid_full;

	tpd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	tpd_parser #(
		.GROUP_SLOTS         (GROUP_SLOTS),
		.WORDS_PER_SUBPACKET (WORDS_PER_SUBPACKET)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (in_data),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	tpd_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
